// ===== src/gpf_pkg.sv =====
// Package: sizes, codes, types and character normalization for the glob path filter.
package gpf_pkg;

  localparam int MAX_RULES = 16;
  localparam int MAX_LEN   = 256;
  localparam int RULE_W    = $clog2(MAX_RULES);
  localparam int LEN_W     = $clog2(MAX_LEN);
  localparam int CNT_W     = LEN_W + 1;
  localparam int TOT_W     = 5;
  localparam int PADDR_W   = RULE_W + LEN_W;

  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_INC   = 2'd1,
    OP_EXC   = 2'd2,
    OP_PATH  = 2'd3
  } op_e;

  typedef enum logic {
    LIST_EXC = 1'b0,
    LIST_INC = 1'b1
  } list_e;

  typedef enum logic [2:0] {
    M_IDLE,
    M_CHECK,
    M_SLOT,
    M_READ,
    M_EVAL,
    M_DONE
  } match_state_e;

  typedef struct packed {
    logic               start;
    logic               ack;
    logic [CNT_W-1:0]   path_len;
    logic [CNT_W-1:0]   base;
    logic [TOT_W-1:0]   inc_tot;
    logic [TOT_W-1:0]   exc_tot;
    logic [CNT_W-1:0]   plen;
    logic               sep;
    logic [7:0]         pat_data;
    logic [7:0]         path_data;
  } match_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic               ok;
    list_e              list;
    logic [RULE_W-1:0]  slot;
    logic [PADDR_W-1:0] pat_addr;
    logic [LEN_W-1:0]   path_addr;
  } match_rsp_t;

  function automatic logic [7:0] norm_char(input logic [7:0] c);
    logic [7:0] b;
    b = c;
    if (b >= CH_UA && b <= CH_UZ) b = b + CASE_OFS;
    if (b == CH_SLASH) b = CH_BSL;
    return b;
  endfunction

endpackage

// ===== src/gpf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module gpf_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/gpf_match.sv =====
// Sequencer that walks the stored patterns and matches each against the path.
module gpf_match (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gpf_pkg::match_req_t req_i,
  output gpf_pkg::match_rsp_t rsp_o
);
  import gpf_pkg::*;

  match_state_e     state_q, state_d;
  list_e            list_q, list_d;
  logic [TOT_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] pi_q, pi_d, ti_q, ti_d, star_at_q, star_at_d, retry_q, retry_d;
  logic             star_q, star_d, ok_q, ok_d;
  logic [TOT_W-1:0] tot;
  logic             pin, tin;

  assign tot = (list_q == LIST_INC) ? req_i.inc_tot : req_i.exc_tot;
  assign pin = pi_q < req_i.plen;
  assign tin = ti_q < req_i.path_len;

  always_comb begin
    state_d   = state_q;
    list_d    = list_q;
    k_d       = k_q;
    pi_d      = pi_q;
    ti_d      = ti_q;
    star_d    = star_q;
    star_at_d = star_at_q;
    retry_d   = retry_q;
    ok_d      = ok_q;
    case (state_q)
      M_IDLE: begin
        if (req_i.start) state_d = M_CHECK;
      end
      M_CHECK: begin
        list_d = LIST_EXC;
        k_d    = '0;
        if (req_i.path_len > CNT_W'(MAX_LEN)) begin
          ok_d    = 1'b0;
          state_d = M_DONE;
        end else begin
          state_d = M_SLOT;
        end
      end
      M_SLOT: begin
        if (k_q == tot) begin
          if (list_q == LIST_EXC && req_i.inc_tot != '0) begin
            list_d = LIST_INC;
            k_d    = '0;
          end else begin
            ok_d    = (list_q == LIST_EXC);
            state_d = M_DONE;
          end
        end else begin
          pi_d    = '0;
          ti_d    = req_i.sep ? '0 : req_i.base;
          star_d  = 1'b0;
          state_d = M_READ;
        end
      end
      M_READ: begin
        state_d = M_EVAL;
      end
      M_EVAL: begin
        state_d = M_READ;
        if (tin) begin
          if (pin && (req_i.pat_data == CH_QUEST || req_i.pat_data == req_i.path_data)) begin
            pi_d = pi_q + CNT_W'(1);
            ti_d = ti_q + CNT_W'(1);
          end else if (pin && req_i.pat_data == CH_STAR) begin
            star_d    = 1'b1;
            star_at_d = pi_q;
            pi_d      = pi_q + CNT_W'(1);
            retry_d   = ti_q;
          end else if (star_q) begin
            pi_d    = star_at_q + CNT_W'(1);
            retry_d = retry_q + CNT_W'(1);
            ti_d    = retry_q + CNT_W'(1);
          end else begin
            k_d     = k_q + TOT_W'(1);
            state_d = M_SLOT;
          end
        end else if (pin && req_i.pat_data == CH_STAR) begin
          pi_d = pi_q + CNT_W'(1);
        end else if (pi_q == req_i.plen) begin
          ok_d    = (list_q == LIST_INC);
          state_d = M_DONE;
        end else begin
          k_d     = k_q + TOT_W'(1);
          state_d = M_SLOT;
        end
      end
      M_DONE: begin
        if (req_i.ack) state_d = M_IDLE;
      end
      default: state_d = M_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.busy      = (state_q != M_IDLE);
    rsp_o.done      = (state_q == M_DONE);
    rsp_o.ok        = ok_q;
    rsp_o.list      = list_q;
    rsp_o.slot      = k_q[RULE_W-1:0];
    rsp_o.pat_addr  = {k_q[RULE_W-1:0], pi_q[LEN_W-1:0]};
    rsp_o.path_addr = ti_q[LEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      list_q  <= LIST_EXC;
      k_q     <= '0;
      star_q  <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      list_q  <= list_d;
      k_q     <= k_d;
      star_q  <= star_d;
      ok_q    <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pi_q      <= pi_d;
    ti_q      <= ti_d;
    star_at_q <= star_at_d;
    retry_q   <= retry_d;
  end

endmodule

// ===== src/glob_path_include_exclude_filter.sv =====
// Top level: loads patterns and paths into memories and reports the filter verdict.
// Pattern, clear and non-final path words are taken one per cycle while not stalled.
// A final path word stalls input through check and done, plus a slot state per pattern
// tried and at the end of each list walked through, and per matcher step a read state
// (pattern and path memory read) then a compare state; a stalled output holds it in done.
// The result word is registered and appears, at the earliest, after the matcher's done state.
// Reset clears the counts and control state; the character memories are not cleared.
module glob_path_include_exclude_filter (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               opcode_i,
  input  logic [7:0]               char_code_i,
  input  logic                     last_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     allowed_o,
  output logic [gpf_pkg::TOT_W-1:0] include_total_out_o,
  output logic [gpf_pkg::TOT_W-1:0] exclude_total_out_o,
  output logic                     filter_enabled_o
);
  import gpf_pkg::*;

  logic [TOT_W-1:0] inc_tot_q, inc_tot_d, exc_tot_q, exc_tot_d;
  logic [CNT_W-1:0] load_len_q, load_len_d, path_len_q, path_len_d, base_q, base_d;
  logic             ovf_q, ovf_d, lsep_q, lsep_d;
  logic [CNT_W-1:0] inc_len_q [MAX_RULES];
  logic [CNT_W-1:0] exc_len_q [MAX_RULES];
  logic             inc_sep_q [MAX_RULES];
  logic             exc_sep_q [MAX_RULES];
  logic             out_valid_q, allowed_q, fen_q;
  logic [TOT_W-1:0] out_inc_q, out_exc_q;

  logic             in_acc, out_free, ack;
  op_e              op;
  logic [7:0]       b;
  logic             pat_byte, load_full, inc_we, exc_we, path_we;
  logic             sep_eff, ovf_eff, commit_inc, commit_exc;
  logic [CNT_W-1:0] len_eff;
  logic [7:0]       inc_rd, exc_rd, path_rd;
  match_req_t       mreq;
  match_rsp_t       mrsp;

  assign in_stall_o = mrsp.busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign op         = op_e'(opcode_i);
  assign b          = norm_char(char_code_i);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign ack        = mrsp.done && out_free;

  assign pat_byte  = in_acc && (op == OP_INC || op == OP_EXC);
  assign load_full = load_len_q >= CNT_W'(MAX_LEN);
  assign inc_we    = pat_byte && !load_full && inc_tot_q < TOT_W'(MAX_RULES);
  assign exc_we    = pat_byte && !load_full && exc_tot_q < TOT_W'(MAX_RULES);
  assign path_we   = in_acc && op == OP_PATH && path_len_q < CNT_W'(MAX_LEN);
  assign ovf_eff   = ovf_q || load_full;
  assign len_eff   = load_full ? load_len_q : load_len_q + CNT_W'(1);
  assign sep_eff   = load_full ? lsep_q
                   : (((load_len_q == '0) ? 1'b0 : lsep_q) || b == CH_BSL);
  assign commit_inc = pat_byte && last_i && op == OP_INC && !ovf_eff &&
                      inc_tot_q < TOT_W'(MAX_RULES);
  assign commit_exc = pat_byte && last_i && op == OP_EXC && !ovf_eff &&
                      exc_tot_q < TOT_W'(MAX_RULES);

  always_comb begin
    inc_tot_d  = inc_tot_q;
    exc_tot_d  = exc_tot_q;
    load_len_d = load_len_q;
    ovf_d      = ovf_q;
    lsep_d     = lsep_q;
    path_len_d = path_len_q;
    base_d     = base_q;
    if (in_acc) begin
      case (op)
        OP_CLEAR: begin
          inc_tot_d  = '0;
          exc_tot_d  = '0;
          load_len_d = '0;
          ovf_d      = 1'b0;
          lsep_d     = 1'b0;
          path_len_d = '0;
          base_d     = '0;
        end
        OP_INC, OP_EXC: begin
          load_len_d = len_eff;
          ovf_d      = ovf_eff;
          lsep_d     = sep_eff;
          if (commit_inc) inc_tot_d = inc_tot_q + TOT_W'(1);
          if (commit_exc) exc_tot_d = exc_tot_q + TOT_W'(1);
          if (last_i) begin
            load_len_d = '0;
            ovf_d      = 1'b0;
            lsep_d     = 1'b0;
          end
        end
        OP_PATH: begin
          if (path_we) begin
            path_len_d = path_len_q + CNT_W'(1);
            if (b == CH_BSL) base_d = path_len_q + CNT_W'(1);
          end else begin
            path_len_d = CNT_W'(MAX_LEN + 1);
          end
        end
        default: ;
      endcase
    end
    if (ack) begin
      path_len_d = '0;
      base_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_tot_q   <= '0;
      exc_tot_q   <= '0;
      load_len_q  <= '0;
      ovf_q       <= 1'b0;
      lsep_q      <= 1'b0;
      path_len_q  <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      inc_tot_q  <= inc_tot_d;
      exc_tot_q  <= exc_tot_d;
      load_len_q <= load_len_d;
      ovf_q      <= ovf_d;
      lsep_q     <= lsep_d;
      path_len_q <= path_len_d;
      base_q     <= base_d;
      if (ack) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_inc) begin
      inc_len_q[inc_tot_q[RULE_W-1:0]] <= len_eff;
      inc_sep_q[inc_tot_q[RULE_W-1:0]] <= sep_eff;
    end
    if (commit_exc) begin
      exc_len_q[exc_tot_q[RULE_W-1:0]] <= len_eff;
      exc_sep_q[exc_tot_q[RULE_W-1:0]] <= sep_eff;
    end
    if (ack) begin
      allowed_q <= mrsp.ok;
      out_inc_q <= inc_tot_q;
      out_exc_q <= exc_tot_q;
      fen_q     <= (inc_tot_q != '0) || (exc_tot_q != '0);
    end
  end

  gpf_ram #(.DEPTH(MAX_RULES * MAX_LEN), .WIDTH(8)) u_inc_ram (
    .clk_i   (clk_i),
    .we_i    (inc_we),
    .waddr_i ({inc_tot_q[RULE_W-1:0], load_len_q[LEN_W-1:0]}),
    .wdata_i (b),
    .raddr_i (mrsp.pat_addr),
    .rdata_o (inc_rd)
  );

  gpf_ram #(.DEPTH(MAX_RULES * MAX_LEN), .WIDTH(8)) u_exc_ram (
    .clk_i   (clk_i),
    .we_i    (exc_we),
    .waddr_i ({exc_tot_q[RULE_W-1:0], load_len_q[LEN_W-1:0]}),
    .wdata_i (b),
    .raddr_i (mrsp.pat_addr),
    .rdata_o (exc_rd)
  );

  gpf_ram #(.DEPTH(MAX_LEN), .WIDTH(8)) u_path_ram (
    .clk_i   (clk_i),
    .we_i    (path_we),
    .waddr_i (path_len_q[LEN_W-1:0]),
    .wdata_i (b),
    .raddr_i (mrsp.path_addr),
    .rdata_o (path_rd)
  );

  always_comb begin
    mreq.start     = in_acc && op == OP_PATH && last_i;
    mreq.ack       = ack;
    mreq.path_len  = path_len_q;
    mreq.base      = base_q;
    mreq.inc_tot   = inc_tot_q;
    mreq.exc_tot   = exc_tot_q;
    mreq.plen      = (mrsp.list == LIST_INC) ? inc_len_q[mrsp.slot] : exc_len_q[mrsp.slot];
    mreq.sep       = (mrsp.list == LIST_INC) ? inc_sep_q[mrsp.slot] : exc_sep_q[mrsp.slot];
    mreq.pat_data  = (mrsp.list == LIST_INC) ? inc_rd : exc_rd;
    mreq.path_data = path_rd;
  end

  gpf_match u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  assign out_valid_o         = out_valid_q;
  assign allowed_o           = allowed_q;
  assign include_total_out_o = out_inc_q;
  assign exclude_total_out_o = out_exc_q;
  assign filter_enabled_o    = fen_q;

endmodule
